// File: hw/rtl/accel_tilt_roll_pitch_top_defines.svh
// assertion macros for the tilt block
`ifndef ACCEL_TILT_ROLL_PITCH_TOP_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_TOP_DEFINES_SVH
`ifndef SYNTH
`define ATRP_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tilt block check failed");
`define ATRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt block check failed");
`else
`define ATRP_ASSERT(label, cond)
`define ATRP_ASSERT_IMP(label, ante, cons)
`endif
`endif

// File: hw/rtl/atrp_pkg.sv
package atrp_pkg;

    localparam int ACCEL_W      = 16;
    localparam int NUM_W        = 17;
    localparam int SQ_W         = 31;
    localparam int SUMSQ_W      = 32;
    localparam int ANGLE_W      = 12;
    localparam int SQRT_STEPS   = 32;
    localparam int NORM_STAGES  = 3;
    localparam int NORM_W       = 59;
    localparam int CORDIC_STEPS = 48;

    // atan(1/2^k) in Q60 by its power series, truncating as it goes
    function automatic logic [63:0] atan_series_pow2(input int k);
        logic [63:0] term;
        logic [63:0] part;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << (60 - k);
        pos  = '0;
        neg  = '0;
        for (int n = 0; n < 64; n++)
        begin
            if (term != 0)
            begin
                part = term / 64'(2 * n + 1);
                if (n % 2 == 1)
                    neg = neg + part;
                else
                    pos = pos + part;
                term = (term >> k) >> k;
            end
        end
        return pos - neg;
    endfunction

    // atan(1/5) when sel is 0, atan(1/239) otherwise, in Q60
    function automatic logic [63:0] atan_series_odd(input bit sel);
        logic [63:0] term;
        logic [63:0] part;
        logic [63:0] pos;
        logic [63:0] neg;
        term = sel ? ((64'd1 << 60) / 64'd239) : ((64'd1 << 60) / 64'd5);
        pos  = '0;
        neg  = '0;
        for (int n = 0; n < 64; n++)
        begin
            if (term != 0)
            begin
                part = term / 64'(2 * n + 1);
                if (n % 2 == 1)
                    neg = neg + part;
                else
                    pos = pos + part;
                term = sel ? ((term / 64'd239) / 64'd239) : ((term / 64'd5) / 64'd5);
            end
        end
        return pos - neg;
    endfunction

    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] val;
        if (i == 0)
            val = (atan_series_odd(1'b0) << 2) - atan_series_odd(1'b1);
        else
            val = atan_series_pow2(i);
        return val;
    endfunction

endpackage

// File: hw/rtl/accel_tilt_roll_pitch_top.sv
// throughput: one sample per cycle while the output is not held;
// 32 square root stages, 3 normalize stages, 48 cordic stages and
// 4 scaling stages form one pipeline under a common enable
// a held output freezes the whole pipeline and stalls the input
// reset: asynchronous active low, clears all valid bits; no other state
`include "accel_tilt_roll_pitch_top_defines.svh"
module accel_tilt_roll_pitch_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [atrp_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [atrp_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [atrp_pkg::ACCEL_W-1:0]  accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [atrp_pkg::ANGLE_W-1:0]  roll_angle,
    output logic signed [atrp_pkg::ANGLE_W-1:0]  pitch_angle
);
    import atrp_pkg::*;

    logic                      en;
    logic                      s0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic signed [ACCEL_W-1:0] s0_x_reg, s0_y_reg, s0_z_reg;
    logic [SQ_W-1:0]           s1_xx_reg, s1_yy_reg, s1_zz_reg;
    logic signed [NUM_W-1:0]   s1_nroll_reg, s1_npitch_reg;
    logic signed [NUM_W-1:0]   s2_nroll_reg, s2_npitch_reg;
    logic [SUMSQ_W-1:0]        s2_ssroll_reg, s2_sspitch_reg;
    logic signed [31:0]        px_next, py_next, pz_next;
    logic                      roll_vld, pitch_vld;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign px_next = s0_x_reg * s0_x_reg;
    assign py_next = s0_y_reg * s0_y_reg;
    assign pz_next = s0_z_reg * s0_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg       <= accel_x;
            s0_y_reg       <= accel_y;
            s0_z_reg       <= accel_z;
            s1_xx_reg      <= px_next[SQ_W-1:0];
            s1_yy_reg      <= py_next[SQ_W-1:0];
            s1_zz_reg      <= pz_next[SQ_W-1:0];
            // no wrap for the most negative count
            s1_nroll_reg   <= -{s0_x_reg[ACCEL_W-1], s0_x_reg};
            s1_npitch_reg  <= {s0_y_reg[ACCEL_W-1], s0_y_reg};
            s2_nroll_reg   <= s1_nroll_reg;
            s2_npitch_reg  <= s1_npitch_reg;
            s2_ssroll_reg  <= {1'b0, s1_yy_reg} + {1'b0, s1_zz_reg};
            s2_sspitch_reg <= {1'b0, s1_xx_reg} + {1'b0, s1_zz_reg};
        end
    end

    atrp_tilt u_roll (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .num     (s2_nroll_reg),
        .sumsq   (s2_ssroll_reg),
        .out_vld (roll_vld),
        .angle   (roll_angle)
    );

    atrp_tilt u_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .num     (s2_npitch_reg),
        .sumsq   (s2_sspitch_reg),
        .out_vld (pitch_vld),
        .angle   (pitch_angle)
    );

    assign out_valid = roll_vld && pitch_vld;

    `ATRP_ASSERT(a_lanes_agree, roll_vld == pitch_vld)
    `ATRP_ASSERT_IMP(a_roll_range, out_valid, roll_angle <= 12'sd1441 && roll_angle >= -12'sd1441)
    `ATRP_ASSERT_IMP(a_pitch_range, out_valid, pitch_angle <= 12'sd1441 && pitch_angle >= -12'sd1441)

endmodule

// File: hw/rtl/atrp_tilt.sv
module atrp_tilt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic signed [atrp_pkg::NUM_W-1:0]    num,
    input  logic [atrp_pkg::SUMSQ_W-1:0]         sumsq,
    output logic                                 out_vld,
    output logic signed [atrp_pkg::ANGLE_W-1:0]  angle
);
    import atrp_pkg::*;

    // square root section
    logic               sq_vld_reg  [0:SQRT_STEPS];
    logic               sq_zero_reg [0:SQRT_STEPS];
    logic               sq_neg_reg  [0:SQRT_STEPS];
    logic [NUM_W-2:0]   sq_mag_reg  [0:SQRT_STEPS];
    logic [63:0]        sq_v_reg    [0:SQRT_STEPS];
    logic [34:0]        sq_rem_reg  [0:SQRT_STEPS];
    logic [31:0]        sq_root_reg [0:SQRT_STEPS];

    // normalize section
    logic               nm_vld_reg  [0:NORM_STAGES];
    logic               nm_zero_reg [0:NORM_STAGES];
    logic               nm_neg_reg  [0:NORM_STAGES];
    logic [NORM_W-1:0]  nm_m_reg    [0:NORM_STAGES];
    logic [NORM_W-1:0]  nm_r_reg    [0:NORM_STAGES];

    // cordic section
    logic               cd_vld_reg  [0:CORDIC_STEPS-1];
    logic               cd_zero_reg [0:CORDIC_STEPS-1];
    logic               cd_neg_reg  [0:CORDIC_STEPS-1];
    logic signed [63:0] cd_x_reg    [0:CORDIC_STEPS-1];
    logic signed [63:0] cd_y_reg    [0:CORDIC_STEPS-1];
    logic signed [63:0] cd_z_reg    [0:CORDIC_STEPS-1];

    // scaling section
    logic               f1_vld_reg, f2_vld_reg, f3_vld_reg, f4_vld_reg;
    logic               f1_zero_reg, f2_zero_reg, f3_zero_reg;
    logic               f1_neg_reg, f2_neg_reg, f3_neg_reg;
    logic [41:0]        f1_q_reg;
    logic [33:0]        f2_ph_reg, f2_pl_reg;
    logic [15:0]        f3_t_reg;
    logic signed [ANGLE_W-1:0] f4_angle_reg;

    logic [63:0]        f1_zabs_next;
    logic [63:0]        f1_round_next;
    logic [55:0]        f3_prod_next;
    logic [31:0]        f4_deg_prod_next;
    logic [10:0]        f4_deg_next;

    // entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (en)
            sq_vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_zero_reg[0] <= (num == '0);
            sq_neg_reg[0]  <= num[NUM_W-1];
            sq_mag_reg[0]  <= num[NUM_W-1] ? 16'(-num) : num[NUM_W-2:0];
            sq_v_reg[0]    <= {sumsq, 32'd0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        logic [34:0] rem_next;
        logic [31:0] root_next;
        logic [34:0] shifted;
        logic [34:0] trial;

        always_comb
        begin
            shifted = {sq_rem_reg[i][32:0], sq_v_reg[i][63:62]};
            trial   = {1'b0, sq_root_reg[i], 2'b01};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {sq_root_reg[i][30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {sq_root_reg[i][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[i+1] <= 1'b0;
            else if (en)
                sq_vld_reg[i+1] <= sq_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_zero_reg[i+1] <= sq_zero_reg[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_mag_reg[i+1]  <= sq_mag_reg[i];
                sq_v_reg[i+1]    <= {sq_v_reg[i][61:0], 2'b00};
                sq_rem_reg[i+1]  <= rem_next;
                sq_root_reg[i+1] <= root_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_vld_reg[0] <= 1'b0;
        else if (en)
            nm_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_zero_reg[0] <= sq_zero_reg[SQRT_STEPS];
            nm_neg_reg[0]  <= sq_neg_reg[SQRT_STEPS];
            nm_m_reg[0]    <= {{(NORM_W-32){1'b0}}, sq_mag_reg[SQRT_STEPS], 16'd0};
            nm_r_reg[0]    <= {{(NORM_W-32){1'b0}}, sq_root_reg[SQRT_STEPS]};
        end
    end

    // leading zero shift, two binary steps per stage
    for (genvar k = 0; k < NORM_STAGES; k++)
    begin : g_norm
        localparam int SH_A = 32 >> (2 * k);
        localparam int SH_B = SH_A >> 1;
        logic [NORM_W-1:0] m_next;
        logic [NORM_W-1:0] r_next;
        logic [NORM_W-1:0] big;

        always_comb
        begin
            m_next = nm_m_reg[k];
            r_next = nm_r_reg[k];
            big    = (m_next > r_next) ? m_next : r_next;
            if (big[NORM_W-1 -: SH_A] == '0)
            begin
                m_next = m_next << SH_A;
                r_next = r_next << SH_A;
                big    = big << SH_A;
            end
            if (big[NORM_W-1 -: SH_B] == '0)
            begin
                m_next = m_next << SH_B;
                r_next = r_next << SH_B;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nm_vld_reg[k+1] <= 1'b0;
            else if (en)
                nm_vld_reg[k+1] <= nm_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_zero_reg[k+1] <= nm_zero_reg[k];
                nm_neg_reg[k+1]  <= nm_neg_reg[k];
                nm_m_reg[k+1]    <= m_next;
                nm_r_reg[k+1]    <= r_next;
            end
        end
    end

    // vectoring rotations, frozen once y reaches zero
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [63:0] ATAN_I = atan_q60(i);
        logic               vld_in, zero_in, neg_in;
        logic signed [63:0] x_in, y_in, z_in;
        logic signed [63:0] xs, ys;
        logic signed [63:0] x_next, y_next, z_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = nm_vld_reg[NORM_STAGES];
            assign zero_in = nm_zero_reg[NORM_STAGES];
            assign neg_in  = nm_neg_reg[NORM_STAGES];
            assign x_in    = $signed({{(64-NORM_W){1'b0}}, nm_r_reg[NORM_STAGES]});
            assign y_in    = $signed({{(64-NORM_W){1'b0}}, nm_m_reg[NORM_STAGES]});
            assign z_in    = '0;
        end
        else
        begin : g_rest
            assign vld_in  = cd_vld_reg[i-1];
            assign zero_in = cd_zero_reg[i-1];
            assign neg_in  = cd_neg_reg[i-1];
            assign x_in    = cd_x_reg[i-1];
            assign y_in    = cd_y_reg[i-1];
            assign z_in    = cd_z_reg[i-1];
        end

        always_comb
        begin
            xs = x_in >>> i;
            ys = y_in >>> i;
            if (y_in == '0)
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = z_in;
            end
            else if (!y_in[63])
            begin
                x_next = x_in + ys;
                y_next = y_in - xs;
                z_next = z_in + ATAN_I;
            end
            else
            begin
                x_next = x_in - ys;
                y_next = y_in + xs;
                z_next = z_in - ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_vld_reg[i] <= 1'b0;
            else if (en)
                cd_vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_zero_reg[i] <= zero_in;
                cd_neg_reg[i]  <= neg_in;
                cd_x_reg[i]    <= x_next;
                cd_y_reg[i]    <= y_next;
                cd_z_reg[i]    <= z_next;
            end
        end
    end

    // radians to sixteenths of a degree
    always_comb
    begin
        f1_zabs_next     = cd_z_reg[CORDIC_STEPS-1][63] ? 64'(-cd_z_reg[CORDIC_STEPS-1])
                                                        : cd_z_reg[CORDIC_STEPS-1];
        f1_round_next    = (f1_zabs_next + 64'd524288) >> 20;
        f3_prod_next     = {1'b0, f2_ph_reg, 21'd0} + {22'd0, f2_pl_reg}
                         + 56'd2748779069440;
        f4_deg_prod_next = {16'd0, f3_t_reg} * 32'd52429;
        f4_deg_next      = f4_deg_prod_next[28:18];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= cd_vld_reg[CORDIC_STEPS-1];
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_zero_reg <= cd_zero_reg[CORDIC_STEPS-1];
            f1_neg_reg  <= cd_neg_reg[CORDIC_STEPS-1] ^ cd_z_reg[CORDIC_STEPS-1][63];
            f1_q_reg    <= f1_round_next[41:0];
            f2_zero_reg <= f1_zero_reg;
            f2_neg_reg  <= f1_neg_reg;
            f2_ph_reg   <= {13'd0, f1_q_reg[41:21]} * 34'd4584;
            f2_pl_reg   <= {13'd0, f1_q_reg[20:0]} * 34'd4584;
            f3_zero_reg <= f2_zero_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_t_reg    <= f3_prod_next[55:40];
            if (f3_zero_reg)
                f4_angle_reg <= '0;
            else if (f3_neg_reg)
                f4_angle_reg <= -$signed({1'b0, f4_deg_next});
            else
                f4_angle_reg <= $signed({1'b0, f4_deg_next});
        end
    end

    assign out_vld = f4_vld_reg;
    assign angle   = f4_angle_reg;

endmodule

// File: bench/accel_tilt_roll_pitch_top_test.sv
module accel_tilt_roll_pitch_top_test;

    import atrp_pkg::*;

    typedef struct {
        logic signed [ACCEL_W-1:0] x;
        logic signed [ACCEL_W-1:0] y;
        logic signed [ACCEL_W-1:0] z;
    } sample_t;

    typedef struct {
        sample_t                   s;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
    } angles_t;

    localparam int STEPS     = 48;
    localparam int MAX_CYC   = 300000;
    localparam int HOLD_FROM = 400;
    localparam int HOLD_LEN  = 400;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;

    longint    atan_q60_tab[STEPS];
    sample_t   pending_samples[$];
    angles_t   expected_angles[$];
    sample_t   next_sample;
    int        offered_cnt;
    int        accepted_cnt;
    int        burst_left;
    int        gap_left;
    int        cycle_cnt;
    int        rx_cycles;
    int        errors;

    accel_tilt_roll_pitch_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle)
    );

    always #5 clk = ~clk;

    // atan(1/m) in Q60 by its power series
    function automatic longint unsigned atan_inv(longint unsigned m);
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned n;
        term = (64'd1 << 60) / m;
        pos  = 0;
        neg  = 0;
        n    = 0;
        while (term != 0)
        begin
            if (n[0])
                neg += term / (2 * n + 1);
            else
                pos += term / (2 * n + 1);
            term = (term / m) / m;
            n++;
        end
        return pos - neg;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in sixteenths of a degree
    function automatic logic signed [ANGLE_W-1:0] tilt_sixteenths(longint num, longint a,
                                                                 longint b);
        longint unsigned mag;
        longint unsigned rt;
        longint unsigned big;
        longint unsigned q40;
        longint unsigned deg;
        longint unsigned den;
        longint          cx;
        longint          cy;
        longint          cz;
        longint          xs;
        longint          ys;
        bit              neg;
        if (num == 0)
            return '0;
        neg = num < 0;
        mag = longint'(neg ? -num : num) << 16;
        rt  = root64(longint'(a * a + b * b) << 32);
        big = mag > rt ? mag : rt;
        while (big < (64'd1 << 58))
        begin
            big <<= 1;
            mag <<= 1;
            rt  <<= 1;
        end
        cx = rt;
        cy = mag;
        cz = 0;
        for (int i = 0; i < STEPS && cy != 0; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0)
            begin
                cx += ys;
                cy -= xs;
                cz += atan_q60_tab[i];
            end
            else
            begin
                cx -= ys;
                cy += xs;
                cz -= atan_q60_tab[i];
            end
        end
        if (cz < 0)
        begin
            neg = !neg;
            cz  = -cz;
        end
        q40 = (longint'(cz) + (64'd1 << 19)) >> 20;
        den = 64'd5 << 40;
        deg = (q40 * 4584 + den / 2) / den;
        return neg ? -ANGLE_W'(deg) : ANGLE_W'(deg);
    endfunction

    task automatic queue_sample(int x, int y, int z);
        sample_t s;
        s.x = ACCEL_W'(x);
        s.y = ACCEL_W'(y);
        s.z = ACCEL_W'(z);
        pending_samples.push_back(s);
    endtask

    function automatic int rand_count();
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 0)
            return $signed(16'($urandom));
        else if (mode == 1)
            return $urandom_range(0, 16) - 8;
        else if (mode == 2)
            return $urandom_range(0, 32767) - 16384;
        return ($urandom_range(0, 1) ? 32767 : -32768) + $urandom_range(0, 3)
               * ($urandom_range(0, 1) ? 1 : 0) * 0;
    endfunction

    task automatic wait_drained();
        while (pending_samples.size() != 0 || accepted_cnt != offered_cnt
               || expected_angles.size() != 0)
            @(posedge clk);
    endtask

    // sender: bursts with gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && accepted_cnt != offered_cnt))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_samples.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                next_sample = pending_samples.pop_front();
                accel_x     <= next_sample.x;
                accel_y     <= next_sample.y;
                accel_z     <= next_sample.z;
                in_valid    <= 1'b1;
                offered_cnt <= offered_cnt + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: stall pattern rotates through four modes, plus one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_FROM + HOLD_LEN)
                out_stall <= 1'b1;
            else
                case ((rx_cycles / 250) % 4)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 3) == 0;
                    2: out_stall <= $urandom_range(0, 1);
                    default: out_stall <= $urandom_range(0, 3) != 0;
                endcase
        end
    end

    always @(posedge clk)
    begin
        angles_t e;
        angles_t got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC)
        begin
            $display("[accel_tilt_roll_pitch_top] ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                e.s.x  = accel_x;
                e.s.y  = accel_y;
                e.s.z  = accel_z;
                e.roll = tilt_sixteenths(-longint'(accel_x), accel_y, accel_z);
                e.pitch = tilt_sixteenths(accel_y, accel_x, accel_z);
                expected_angles.push_back(e);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_valid && !out_stall)
            begin
                got.roll  = roll_angle;
                got.pitch = pitch_angle;
                if (expected_angles.size() == 0)
                begin
                    $display("%0t: unexpected transfer roll %0d pitch %0d", $time,
                             got.roll, got.pitch);
                    errors++;
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (got.roll !== e.roll)
                    begin
                        $display("%0t: roll for (%0d,%0d,%0d) expected %0d actual %0d",
                                 $time, e.s.x, e.s.y, e.s.z, e.roll, got.roll);
                        errors++;
                    end
                    if (got.pitch !== e.pitch)
                    begin
                        $display("%0t: pitch for (%0d,%0d,%0d) expected %0d actual %0d",
                                 $time, e.s.x, e.s.y, e.s.z, e.pitch, got.pitch);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int c;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        accel_x      = '0;
        accel_y      = '0;
        accel_z      = '0;
        out_stall    = 1'b0;
        offered_cnt  = 0;
        accepted_cnt = 0;
        burst_left   = 1;
        gap_left     = 0;
        cycle_cnt    = 0;
        rx_cycles    = 0;
        errors       = 0;
        atan_q60_tab[0] = 4 * atan_inv(5) - atan_inv(239);
        for (int i = 1; i < STEPS; i++)
            atan_q60_tab[i] = atan_inv(64'd1 << i);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zeros, zero numerators, zero roots, extremes
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 100);
        queue_sample(-32768, 0, 0);
        queue_sample(32767, 0, 0);
        queue_sample(0, -32768, 0);
        queue_sample(0, 32767, 0);
        queue_sample(0, 0, -32768);
        queue_sample(0, 0, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, 32767, -32768);
        queue_sample(32767, -32768, 32767);
        queue_sample(1, 0, 0);
        queue_sample(0, 1, 0);
        queue_sample(-1, -1, 0);
        queue_sample(1, -1, 1);
        queue_sample(-32768, 32767, 0);
        queue_sample(16384, 0, 16384);
        queue_sample(0, 0, 1);
        queue_sample(-1, 0, 0);
        wait_drained();

        for (int n = 0; n < 450; n++)
            queue_sample(rand_count(), rand_count(), rand_count());
        wait_drained();
        for (int n = 0; n < 450; n++)
        begin
            c = $urandom_range(0, 9);
            if (c == 0)
                queue_sample(rand_count(), 0, 0);
            else if (c == 1)
                queue_sample(0, rand_count(), 0);
            else
                queue_sample(rand_count(), rand_count(), rand_count());
        end
        wait_drained();
        repeat (150) @(posedge clk);
        if (errors == 0 && expected_angles.size() == 0)
            $display("[accel_tilt_roll_pitch_top] OK");
        else
            $display("[accel_tilt_roll_pitch_top] ERROR");
        $finish;
    end

endmodule
